// File: hw/rtl/swfr_pkg.sv
`timescale 1ns / 1ps

package swfr_pkg;

    // Window and field geometry
    localparam int WIN_FRAMES  = 32;
    localparam int TIME_W      = 63;
    localparam int RATE_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int HELD_W      = 6;
    localparam int FRAC_BITS   = 16;

    localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

    // Derived widths
    localparam int CNT_W  = $clog2(WIN_FRAMES + 1);
    localparam int SLOT_W = $clog2(WIN_FRAMES);
    localparam int MUL_W  = $clog2(64'(WIN_FRAMES - 1) * NS_PER_SEC + 64'd1);
    localparam int NUM_W  = MUL_W + FRAC_BITS;
    localparam int STEP_W = $clog2(NUM_W);

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NEG  = 2'd3;

    // One classified request, ready for the divider
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    held;
        logic [NUM_W-1:0]    num;
        logic [TIME_W-1:0]   span;
    } t_job;

endpackage

// File: hw/rtl/swfr_front.sv
`timescale 1ns / 1ps

module swfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [swfr_pkg::TIME_W-1:0] i_frame_time_ns,
    output logic              o_stall,
    output logic              o_push,
    output swfr_pkg::t_job    o_job,
    input  logic              i_full
);
    import swfr_pkg::*;

    logic [TIME_W-1:0] r_ring [WIN_FRAMES];
    logic [TIME_W-1:0] r_newest;
    logic [TIME_W-1:0] r_old;
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_slot;
    logic              r_pend;

    logic              accept;
    logic [CNT_W-1:0]  n_count;
    logic [SLOT_W-1:0] n_slot;
    logic [SLOT_W-1:0] first;
    logic [TIME_W:0]   diff;
    logic [MUL_W-1:0]  prod;

    assign accept = i_valid && !r_pend;
    assign o_stall = r_pend;
    assign o_push  = r_pend && !i_full;

    // Advance count and write slot; find the oldest held slot
    always_comb begin
        n_count = (r_count == CNT_W'(WIN_FRAMES)) ? r_count : r_count + CNT_W'(1);
        n_slot  = (r_slot == SLOT_W'(WIN_FRAMES - 1)) ? '0 : r_slot + SLOT_W'(1);
        first   = (n_count == CNT_W'(WIN_FRAMES)) ? n_slot : '0;
    end

    // Write the new timestamp and read the oldest one
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_slot] <= i_frame_time_ns;
            r_old          <= r_ring[first];
            r_newest       <= i_frame_time_ns;
        end
    end

    // Hold window state and the pending request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_slot  <= '0;
            r_pend  <= 1'b0;
        end else if (accept) begin
            r_count <= n_count;
            r_slot  <= n_slot;
            r_pend  <= 1'b1;
        end else if (o_push) begin
            r_pend  <= 1'b0;
        end
    end

    // Classify the request and form numerator and span
    always_comb begin
        diff = {1'b0, r_newest} - {1'b0, r_old};
        prod = MUL_W'(r_count - CNT_W'(1)) * MUL_W'(NS_PER_SEC);
        o_job.held = r_count;
        o_job.num  = {prod, FRAC_BITS'(0)};
        o_job.span = diff[TIME_W-1:0];
        if (r_count < CNT_W'(2)) begin
            o_job.status = ST_FEW;
        end else if (r_newest == r_old) begin
            o_job.status = ST_ZERO;
        end else if (diff[TIME_W]) begin
            o_job.status = ST_NEG;
        end else begin
            o_job.status = ST_OK;
        end
    end

endmodule

// File: hw/rtl/swfr_queue.sv
`timescale 1ns / 1ps

module swfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  swfr_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output swfr_pkg::t_job o_job,
    output logic           o_empty
);
    import swfr_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hw/rtl/swfr_back.sv
`timescale 1ns / 1ps

module swfr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  swfr_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [swfr_pkg::RATE_W-1:0]   o_rate_fixed,
    output logic [swfr_pkg::STATUS_W-1:0] o_status,
    output logic [swfr_pkg::HELD_W-1:0]   o_frames_held
);
    import swfr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_quo;
    logic [TIME_W-1:0]   r_rem;
    logic [TIME_W-1:0]   r_span;
    logic [STEP_W-1:0]   r_step;
    logic [STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]    r_held;
    logic                r_out_valid;
    logic [RATE_W-1:0]   r_out_rate;
    logic [STATUS_W-1:0] r_out_status;
    logic [HELD_W-1:0]   r_out_held;

    logic [TIME_W:0]     rem_sh;
    logic [TIME_W:0]     rem_sub;
    logic                ge;
    logic [RATE_W-1:0]   sat_rate;
    logic                out_free;

    assign o_pop         = (r_state == S_IDLE) && !i_empty;
    assign out_free      = !r_out_valid || !i_stall;
    assign o_valid       = r_out_valid;
    assign o_rate_fixed  = r_out_rate;
    assign o_status      = r_out_status;
    assign o_frames_held = r_out_held;

    // One restoring divide step, and saturation of the quotient
    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_span};
        ge      = (rem_sh >= {1'b0, r_span});
        sat_rate = (|r_quo[NUM_W-1:RATE_W]) ? '1 : r_quo[RATE_W-1:0];
    end

    // Run the divider and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Drop a delivered result unless a new one replaces it
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_num    <= i_job.num;
                        r_span   <= i_job.span;
                        r_status <= i_job.status;
                        r_held   <= i_job.held;
                        r_rem    <= '0;
                        r_quo    <= '0;
                        r_step   <= STEP_W'(NUM_W - 1);
                        r_state  <= (i_job.status == ST_OK) ? S_RUN : S_DONE;
                    end
                end
                S_RUN: begin
                    r_rem <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], ge};
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_rate   <= (r_status == ST_OK) ? sat_rate : '0;
                        r_out_status <= r_status;
                        r_out_held   <= HELD_W'(r_held);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/sliding_window_frame_rate.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     i_valid / o_stall    i_frame_time_ns
// output    o_valid / i_stall    o_rate_fixed, o_status, o_frames_held
//
// The front writes each timestamp into the ring, registers it and the oldest
// one, then classifies the request; a two-entry queue feeds the back, which
// runs a bit-serial divider of 51 steps for a request with ok status only.
// Reset is synchronous and active low and clears counters, pointers and
// valid flags; the ring needs no clearing. A stalled result holds in the
// output register while the next divide runs.

module sliding_window_frame_rate (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic [swfr_pkg::TIME_W-1:0]   i_frame_time_ns,
    output logic o_valid,
    input  logic i_stall,
    output logic [swfr_pkg::RATE_W-1:0]   o_rate_fixed,
    output logic [swfr_pkg::STATUS_W-1:0] o_status,
    output logic [swfr_pkg::HELD_W-1:0]   o_frames_held
);
    import swfr_pkg::*;

    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    swfr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_frame_time_ns (i_frame_time_ns),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_job           (push_job),
        .i_full          (full)
    );

    swfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    swfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (pop_job),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rate_fixed  (o_rate_fixed),
        .o_status      (o_status),
        .o_frames_held (o_frames_held)
    );

endmodule
